// File: rtl/md5_pkg.sv
`timescale 1ns / 1ps
package md5_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned Rounds = 64;

    localparam logic [WordW-1:0] InitA = 32'h67452301;
    localparam logic [WordW-1:0] InitB = 32'hefcdab89;
    localparam logic [WordW-1:0] InitC = 32'h98badcfe;
    localparam logic [WordW-1:0] InitD = 32'h10325476;

    localparam logic [7:0] PadByte  = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    typedef enum logic [2:0] {
        t_st_idle,
        t_st_pad,
        t_st_round,
        t_st_fold,
        t_st_emit
    } t_state;

    typedef struct packed {
        logic       start;
        logic       busy;
        logic       done;
    } t_round_ctl;

    function automatic logic [WordW-1:0] round_add(input logic [5:0] r);
        logic [WordW-1:0] k;
        begin
            case (r)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = '0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            case ({r[5:4], r[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    // Message word used by round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] g;
        begin
            case (r[5:4])
                2'd0: g = r[3:0];
                2'd1: g = 4'(5 * r[3:0] + 1);
                2'd2: g = 4'(3 * r[3:0] + 5);
                default: g = 4'(7 * r[3:0]);
            endcase
            return g;
        end
    endfunction

endpackage

// File: rtl/md5_ram.sv
`timescale 1ns / 1ps
module md5_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/md5_round.sv
`timescale 1ns / 1ps
// Shared round unit: runs the 64 MD5 rounds, one round per cycle. The message word
// for round r is read from the RAM in the cycle before round r (read address driven here).
module md5_round
    import md5_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WordW-1:0] i_a,
    input  logic [WordW-1:0] i_b,
    input  logic [WordW-1:0] i_c,
    input  logic [WordW-1:0] i_d,
    input  logic [WordW-1:0] i_m,
    output logic [3:0]       o_raddr,
    output t_round_ctl       o_ctl,
    output logic [WordW-1:0] o_a,
    output logic [WordW-1:0] o_b,
    output logic [WordW-1:0] o_c,
    output logic [WordW-1:0] o_d
);
    logic [WordW-1:0] r_a, r_b, r_c, r_d;
    logic [WordW-1:0] n_a, n_b, n_c, n_d;
    logic [5:0]       r_rnd, n_rnd;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [WordW-1:0] f, sum;
    logic [4:0]       sh;

    // Prefetch: at start the word for round 0, while busy the next round's
    assign o_raddr = i_start ? msg_index(6'd0) : msg_index(6'(r_rnd + 6'd1));

    always_comb begin
        case (r_rnd[5:4])
            2'd0: f = (r_b & r_c) | (~r_b & r_d);
            2'd1: f = (r_d & r_b) | (~r_d & r_c);
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f + round_add(r_rnd) + i_m;
        sh  = rot_amount(r_rnd);
    end

    always_comb begin
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d;
        n_rnd  = r_rnd;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_a = i_a; n_b = i_b; n_c = i_c; n_d = i_d;
            n_rnd  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_a = r_d;
            n_d = r_c;
            n_c = r_b;
            n_b = r_b + ((sum << sh) | (sum >> (6'd32 - {1'b0, sh})));
            n_rnd = r_rnd + 6'd1;
            if (r_rnd == 6'(Rounds - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_rnd  <= n_rnd;
        end
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d;
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_a = r_a;
    assign o_b = r_b;
    assign o_c = r_c;
    assign o_d = r_d;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("round unit restarted while busy");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while still busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held for two cycles");
endmodule

// File: rtl/md5_message_digest.sv
`timescale 1ns / 1ps
// Channel | direction | payload                                | handshake
// input   | in        | i_data_byte, i_has_byte, i_end_of_message | i_valid / o_stall
// output  | out       | o_digest_word, o_word_index, o_final_word  | o_valid / i_stall
//
// A byte that does not fill the block is accepted and merged into the word being
// built in the same cycle. A byte that fills the block is accepted, then the shared
// round unit is started and runs the 64 rounds one per cycle, then come the done
// cycle and the fold into the chaining words. Closing pads one byte per cycle up
// to the length words and writes them, compresses once or twice and emits four beats.
// Reset is synchronous and active low; the block buffer is not cleared. A stall
// on the output holds the current digest beat and keeps o_stall high.
module md5_message_digest
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_final_word
);
    t_state           r_state, n_state;
    logic [WordW-1:0] r_ca, r_cb, r_cc, r_cd;
    logic [WordW-1:0] n_ca, n_cb, n_cc, n_cd;
    logic [5:0]       r_fill, n_fill;
    logic [63:0]      r_len, n_len;
    logic [63:0]      r_total, n_total;
    logic [WordW-1:0] r_word, n_word;   // word under assembly
    logic             r_closing, n_closing;
    logic             r_last_blk, n_last_blk;
    logic [1:0]       r_idx, n_idx;
    logic             r_pend, n_pend;   // message closing in progress

    // byte placement request (one byte per cycle)
    logic             put_en;
    logic [7:0]       put_byte;
    logic             we;
    logic [3:0]       waddr;
    logic [WordW-1:0] wdata;
    logic             rnd_start;
    logic [3:0]       raddr;
    logic [WordW-1:0] rdata;
    t_round_ctl       rctl;
    logic [WordW-1:0] ra, rb, rc, rd;
    logic [WordW-1:0] word_nx;
    logic             accept;

    md5_ram #(.Width(WordW), .Depth(16)) u_buf (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    md5_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(rnd_start),
        .i_a(r_ca), .i_b(r_cb), .i_c(r_cc), .i_d(r_cd), .i_m(rdata),
        .o_raddr(raddr), .o_ctl(rctl),
        .o_a(ra), .o_b(rb), .o_c(rc), .o_d(rd)
    );

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != t_st_idle);

    always_comb begin
        case (r_fill[1:0])
            2'd0: word_nx = {24'd0, put_byte};
            2'd1: word_nx = {16'd0, put_byte, r_word[7:0]};
            2'd2: word_nx = {8'd0, put_byte, r_word[15:0]};
            default: word_nx = {put_byte, r_word[23:0]};
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_ca = r_ca; n_cb = r_cb; n_cc = r_cc; n_cd = r_cd;
        n_fill = r_fill; n_len = r_len; n_total = r_total;
        n_word = r_word; n_closing = r_closing; n_last_blk = r_last_blk;
        n_idx = r_idx;
        put_en = 1'b0; put_byte = 8'd0;
        we = 1'b0; waddr = r_fill[5:2]; wdata = word_nx;
        rnd_start = 1'b0;
        case (r_state)
            t_st_idle: begin
                if (accept) begin
                    if (i_has_byte) begin
                        put_en = 1'b1; put_byte = i_data_byte;
                        n_len = r_len + 64'd8;
                    end
                    n_closing = i_end_of_message;
                    n_total = i_has_byte ? r_len + 64'd8 : r_len;
                    if (i_has_byte && r_fill == 6'd63) begin
                        n_last_blk = 1'b0;
                        n_state = t_st_round;
                    end else if (i_end_of_message) begin
                        n_state = t_st_pad;
                    end
                end
            end
            t_st_pad: begin
                // 0x80 first, then zeros; the length block ends in the length words
                if (r_closing) begin
                    put_en = 1'b1;
                    put_byte = PadByte;
                    n_closing = 1'b0;
                    n_last_blk = (r_fill < LenStart);
                    if (r_fill == 6'd63) begin
                        n_state = t_st_round;
                    end
                end else if (r_last_blk && r_fill == LenStart) begin
                    we = 1'b1; waddr = 4'd14; wdata = r_total[31:0];
                    n_fill = 6'd60;
                end else if (r_last_blk && r_fill == 6'd60) begin
                    we = 1'b1; waddr = 4'd15; wdata = r_total[63:32];
                    n_fill = 6'd0;
                    n_state = t_st_round;
                end else begin
                    put_en = 1'b1;
                    put_byte = 8'd0;
                    if (r_fill == 6'd63) begin
                        n_state = t_st_round;
                    end
                end
            end
            t_st_round: begin
                if (!rctl.busy && !rctl.done) begin
                    rnd_start = 1'b1;
                end
                if (rctl.done) begin
                    n_state = t_st_fold;
                end
            end
            t_st_fold: begin
                n_ca = r_ca + ra; n_cb = r_cb + rb;
                n_cc = r_cc + rc; n_cd = r_cd + rd;
                n_fill = 6'd0;
                if (r_last_blk) begin
                    n_idx = 2'd0;
                    n_state = t_st_emit;
                end else if (r_pend) begin
                    // still closing: the next block carries the pad or the length
                    n_last_blk = !r_closing;
                    n_state = t_st_pad;
                end else begin
                    n_state = t_st_idle;
                end
            end
            t_st_emit: begin
                if (!i_stall) begin
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        n_ca = InitA; n_cb = InitB; n_cc = InitC; n_cd = InitD;
                        n_len = '0; n_fill = '0; n_last_blk = 1'b0;
                        n_state = t_st_idle;
                    end
                end
            end
            default: n_state = t_st_idle;
        endcase
        if (put_en) begin
            n_word = word_nx;
            if (r_fill[1:0] == 2'd3) begin
                we = 1'b1; waddr = r_fill[5:2]; wdata = word_nx;
            end
            n_fill = r_fill + 6'd1;
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (r_state == t_st_idle && accept) begin
            n_pend = i_end_of_message;
        end else if (r_state == t_st_emit) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_st_idle;
            r_ca <= InitA; r_cb <= InitB; r_cc <= InitC; r_cd <= InitD;
            r_fill <= '0;
            r_len <= '0;
            r_closing <= 1'b0;
            r_last_blk <= 1'b0;
            r_idx <= '0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ca <= n_ca; r_cb <= n_cb; r_cc <= n_cc; r_cd <= n_cd;
            r_fill <= n_fill;
            r_len <= n_len;
            r_closing <= n_closing;
            r_last_blk <= n_last_blk;
            r_idx <= n_idx;
            r_pend <= n_pend;
        end
        r_total <= n_total;
        r_word <= n_word;
    end

    assign o_valid = (r_state == t_st_emit);
    always_comb begin
        case (r_idx)
            2'd0: o_digest_word = r_ca;
            2'd1: o_digest_word = r_cb;
            2'd2: o_digest_word = r_cc;
            default: o_digest_word = r_cd;
        endcase
    end
    assign o_word_index = r_idx;
    assign o_final_word = (r_idx == 2'd3);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_idx))
        else $error("digest beat dropped under stall");
    a_emit_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_last_blk) else $error("emit without final block");
    a_idle_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_word && o_valid && !i_stall |=> r_fill == 6'd0)
        else $error("fill not cleared after digest");
endmodule

// File: tb/tb_md5_message_digest.sv
`timescale 1ns / 1ps
module tb_md5_message_digest
    import md5_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        end_of_msg;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        final_word;

    md5_message_digest u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_data_byte      (data_byte),
        .i_has_byte       (has_byte),
        .i_end_of_message (end_of_msg),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_digest_word    (digest_word),
        .o_word_index     (word_index),
        .o_final_word     (final_word)
    );

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } digest_beat_t;

    // Predictor state: chaining words, block buffer, fill and bit length
    logic [31:0] chain_q [4];
    logic [31:0] blk_q [16];
    logic [5:0]  fill_q;
    logic [63:0] nbits_q;

    digest_beat_t digest_fifo [$];
    int errors;
    int beats_seen;
    int messages_done;
    int cycle_count;
    int stall_left;
    bit quiet_phase;

    localparam int unsigned CycleLimit = 2000000;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Give up on a hang
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("md5_message_digest verification failed");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // One MD5 compression over blk_q, folded into chain_q
    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, t;
        int g;
        int s;
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                f = (b & c) | (~b & d); g = r;
            end else if (r < 32) begin
                f = (d & b) | (~d & c); g = (5 * r + 1) % 16;
            end else if (r < 48) begin
                f = b ^ c ^ d; g = (3 * r + 5) % 16;
            end else begin
                f = c ^ (b | ~d); g = (7 * r) % 16;
            end
            case ((r / 16) * 4 + r % 4)
                0: s = 7;   1: s = 12;  2: s = 17;  3: s = 22;
                4: s = 5;   5: s = 9;   6: s = 14;  7: s = 20;
                8: s = 4;   9: s = 11;  10: s = 16; 11: s = 23;
                12: s = 6;  13: s = 10; 14: s = 15; default: s = 21;
            endcase
            t = d; d = c; c = b;
            b = b + rotl(a + f + round_add(6'(r)) + blk_q[g], s);
            a = t;
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
    endtask

    task automatic absorb_byte(input logic [7:0] v);
        blk_q[fill_q[5:2]][8 * fill_q[1:0] +: 8] = v;
        fill_q = fill_q + 6'd1;
        if (fill_q == 6'd0) md5_compress();
    endtask

    task automatic init_digest();
        chain_q[0] = InitA; chain_q[1] = InitB; chain_q[2] = InitC; chain_q[3] = InitD;
        fill_q = '0;
        nbits_q = '0;
    endtask

    // Advance the predictor by one beat and queue any digest it closes
    task automatic predict_beat(input logic [7:0] v, input logic hb, input logic eom);
        logic [63:0] total;
        if (hb) begin
            nbits_q += 64'd8;
            absorb_byte(v);
        end
        if (eom) begin
            total = nbits_q;
            absorb_byte(PadByte);
            if (fill_q > LenStart)
                while (fill_q != 6'd0) absorb_byte(8'h00);
            while (fill_q < LenStart) absorb_byte(8'h00);
            blk_q[14] = total[31:0];
            blk_q[15] = total[63:32];
            md5_compress();
            for (int k = 0; k < 4; k++)
                digest_fifo.push_back('{chain_q[k], 2'(k), k == 3});
            init_digest();
        end
    endtask

    // Send one beat, with a random gap ahead of it while idling is on
    task automatic send_beat(input logic [7:0] v, input logic hb, input logic eom);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= v;
        has_byte   <= hb;
        end_of_msg <= eom;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_beat(v, hb, eom);
    endtask

    // Receiver stalls at random, in bursts of random length
    always @(posedge clk) begin
        if (!rst_n || quiet_phase) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (out_stall) begin
            out_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end
    end

    // Check each accepted digest beat against the oldest prediction
    always @(posedge clk) begin
        digest_beat_t want;
        if (rst_n && out_valid && !out_stall) begin
            beats_seen++;
            if (digest_fifo.size() == 0) begin
                report($sformatf("unexpected digest beat %h", digest_word));
            end else begin
                want = digest_fifo.pop_front();
                if (digest_word !== want.word)
                    report($sformatf("word %h, want %h", digest_word, want.word));
                if (word_index !== want.idx)
                    report($sformatf("index %0d, want %0d", word_index, want.idx));
                if (final_word !== want.last)
                    report($sformatf("final flag %b, want %b", final_word, want.last));
                if (want.last) messages_done++;
            end
        end
    end

    task automatic send_message(input int len);
        for (int n = 0; n < len; n++)
            send_beat(8'($urandom_range(0, 255)), 1'b1, n == len - 1);
        if (len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    // Empty message, "abc" with bubbles, byte extremes and a close on an empty beat
    task automatic test_directed();
        string abc;
        abc = "abc";
        send_beat(8'hff, 1'b0, 1'b1);
        for (int n = 0; n < 3; n++) begin
            send_beat(8'h5a, 1'b0, 1'b0);
            send_beat(abc[n], 1'b1, n == 2);
        end
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'haa, 1'b0, 1'b1);
        send_beat(8'h55, 1'b1, 1'b1);
    endtask

    // Lengths around the 55/56 padding split and the 64-byte block edge
    task automatic test_padding_edges();
        int lens [6] = '{55, 56, 57, 63, 64, 65};
        foreach (lens[i]) send_message(lens[i]);
    endtask

    // Mostly short messages with the odd empty beat mixed in
    task automatic test_random_messages(input int budget);
        int len;
        int sent;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 130) : $urandom_range(0, 20);
            for (int n = 0; n < len; n++) begin
                if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
                send_beat(8'($urandom), 1'b1, n == len - 1);
            end
            if (len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
            sent += (len == 0) ? 1 : len;
        end
    endtask

    initial begin
        rst_n = 1'b0; in_valid = 1'b0; data_byte = '0; has_byte = 1'b0;
        end_of_msg = 1'b0; out_stall = 1'b0;
        errors = 0; beats_seen = 0; messages_done = 0; cycle_count = 0;
        stall_left = 0;
        quiet_phase = 1'b0;
        init_digest();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_padding_edges();
        test_random_messages(70);
        quiet_phase = 1'b1;
        test_random_messages(40);
        in_valid <= 1'b0;

        // Drain outstanding digests, then let the block settle
        while (digest_fifo.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d messages (%0d digest beats): empty, padding split, block edges,",
                 messages_done, beats_seen);
        $display("random lengths with bubbles and stalls on both channels.");
        if (errors == 0)
            $display("md5_message_digest verification clean");
        else
            $display("md5_message_digest verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/md5_pkg.sv
rtl/md5_ram.sv
rtl/md5_round.sv
rtl/md5_message_digest.sv
tb/tb_md5_message_digest.sv
